/* src/wocm_pkg.sv */
// Shared types and constants for the wrench overload cancel monitor.
// No dependencies; imported by wocm_sq3 and the top level.
package wocm_pkg;

  localparam int unsigned COMP_W   = 20;  // force/torque component width
  localparam int unsigned LIMIT_W  = 19;  // limit register width
  localparam int unsigned MAG_W    = 40;  // sum of three squares
  localparam int unsigned LIM_SQ_W = 2 * LIMIT_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned CANCEL_BURST = 5;
  localparam int unsigned HOLD_TICKS   = 100;
  localparam int unsigned BURST_W = $clog2(CANCEL_BURST + 1);
  localparam int unsigned HOLD_W  = $clog2(HOLD_TICKS + 1);

  localparam logic [LIMIT_W-1:0] FORCE_USER_RST    = LIMIT_W'(50000);
  localparam logic [LIMIT_W-1:0] TORQUE_USER_RST   = LIMIT_W'(5000);
  localparam logic [LIMIT_W-1:0] FORCE_BIASED_RST  = LIMIT_W'(10000);
  localparam logic [LIMIT_W-1:0] TORQUE_BIASED_RST = LIMIT_W'(800);

  typedef logic [MAG_W-1:0]    mag_t;
  typedef logic [LIM_SQ_W-1:0] lim_sq_t;

  localparam lim_sq_t FORCE_USER_SQ_RST =
    LIM_SQ_W'(FORCE_USER_RST) * LIM_SQ_W'(FORCE_USER_RST);
  localparam lim_sq_t TORQUE_USER_SQ_RST =
    LIM_SQ_W'(TORQUE_USER_RST) * LIM_SQ_W'(TORQUE_USER_RST);
  localparam lim_sq_t FORCE_BIASED_SQ_RST =
    LIM_SQ_W'(FORCE_BIASED_RST) * LIM_SQ_W'(FORCE_BIASED_RST);
  localparam lim_sq_t TORQUE_BIASED_SQ_RST =
    LIM_SQ_W'(TORQUE_BIASED_RST) * LIM_SQ_W'(TORQUE_BIASED_RST);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_USER    = 3'd0,
    REG_TORQUE_USER   = 3'd1,
    REG_FORCE_BIASED  = 3'd2,
    REG_TORQUE_BIASED = 3'd3,
    REG_BIAS_ACTIVE   = 3'd4
  } cfg_reg_e;

  // Three component squares of one vector.
  typedef struct packed {
    mag_t a;
    mag_t b;
    mag_t c;
  } sq3_t;

endpackage

/* src/wrench_overload_cancel_monitor_top.sv */
// Top level of the wrench overload cancel monitor: sample register, limit
// selection, cancel burst / hold-off counters. Depends on wocm_pkg, wocm_sq3.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one force/torque sample
//   per beat. Output channel (out_valid_o / out_ready_i) returns one result
//   beat per sample, in order: cancel, over flags, squared magnitudes and the
//   limit set used.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write it only while no sample is in flight. Limits are squared at write.
//   Staging: an accepted sample is held in the input register, then its
//   result in the result register.
//   Throughput: one sample per cycle while out_ready_i stays high; the two registers each hold one beat.
//   The squares, sums and limit compares are the longest path into the
//   result register.
//   Receiver stall: out_ready_i low holds the result; the input register
//   behind it fills, then in_ready_o drops. No beat is lost.
//   Reset: limits return to their defaults, bias inactive, counters loaded
//   with the burst length and hold-off count, cancel low, pipeline empty.
module wrench_overload_cancel_monitor_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [wocm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [wocm_pkg::LIMIT_W-1:0]         cfg_data_i,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wocm_pkg::COMP_W-1:0]   force_x_i,
  input  logic signed [wocm_pkg::COMP_W-1:0]   force_y_i,
  input  logic signed [wocm_pkg::COMP_W-1:0]   force_z_i,
  input  logic signed [wocm_pkg::COMP_W-1:0]   torque_x_i,
  input  logic signed [wocm_pkg::COMP_W-1:0]   torque_y_i,
  input  logic signed [wocm_pkg::COMP_W-1:0]   torque_z_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 cancel_o,
  output logic                                 force_over_o,
  output logic                                 torque_over_o,
  output logic [wocm_pkg::MAG_W-1:0]           force_mag_sq_o,
  output logic [wocm_pkg::MAG_W-1:0]           torque_mag_sq_o,
  output logic                                 using_biased_limits_o
);
  import wocm_pkg::*;

  // ---------------- configuration ----------------
  lim_sq_t cfg_sq;
  lim_sq_t flim_user_sq_q, tlim_user_sq_q, flim_bias_sq_q, tlim_bias_sq_q;
  logic    bias_active_q;
  logic    fresh_bias_q, fresh_bias_d;

  assign cfg_sq = LIM_SQ_W'(cfg_data_i) * LIM_SQ_W'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flim_user_sq_q <= FORCE_USER_SQ_RST;
      tlim_user_sq_q <= TORQUE_USER_SQ_RST;
      flim_bias_sq_q <= FORCE_BIASED_SQ_RST;
      tlim_bias_sq_q <= TORQUE_BIASED_SQ_RST;
      bias_active_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FORCE_USER:    flim_user_sq_q <= cfg_sq;
        REG_TORQUE_USER:   tlim_user_sq_q <= cfg_sq;
        REG_FORCE_BIASED:  flim_bias_sq_q <= cfg_sq;
        REG_TORQUE_BIASED: tlim_bias_sq_q <= cfg_sq;
        REG_BIAS_ACTIVE:   bias_active_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_q, out_valid_q;
  logic out_en, s1_en;

  assign out_en = !out_valid_q || out_ready_i;
  assign s1_en  = !s1_valid_q || out_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_q  <= in_valid_i;
      if (out_en) out_valid_q <= s1_valid_q;
    end
  end

  // ---------------- input register ----------------
  logic signed [COMP_W-1:0] fx_q, fy_q, fz_q, tx_q, ty_q, tz_q;

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      fx_q <= force_x_i;
      fy_q <= force_y_i;
      fz_q <= force_z_i;
      tx_q <= torque_x_i;
      ty_q <= torque_y_i;
      tz_q <= torque_z_i;
    end
  end

  // ---------------- squares ----------------
  sq3_t fsq, tsq;

  wocm_sq3 u_force_sq (
    .a_i  (fx_q),
    .b_i  (fy_q),
    .c_i  (fz_q),
    .sq_o (fsq)
  );

  wocm_sq3 u_torque_sq (
    .a_i  (tx_q),
    .b_i  (ty_q),
    .c_i  (tz_q),
    .sq_o (tsq)
  );

  // ---------------- sums, compare, counters ----------------
  mag_t    fsum, tsum;
  lim_sq_t flim_sel, tlim_sel;
  logic    biased_sel, f_over, t_over, overload;
  logic    advance;

  logic [BURST_W-1:0] burst_q, burst_d;
  logic [HOLD_W-1:0]  hold_q, hold_d;
  logic               cancel_q, cancel_d;

  assign fsum = fsq.a + fsq.b + fsq.c;
  assign tsum = tsq.a + tsq.b + tsq.c;

  assign biased_sel = bias_active_q && !fresh_bias_q;
  assign flim_sel   = biased_sel ? flim_bias_sq_q : flim_user_sq_q;
  assign tlim_sel   = biased_sel ? tlim_bias_sq_q : tlim_user_sq_q;

  assign f_over   = fsum > MAG_W'(flim_sel);
  assign t_over   = tsum > MAG_W'(tlim_sel);
  assign overload = f_over || t_over;

  assign advance = out_en && s1_valid_q;

  always_comb begin
    burst_d      = burst_q;
    hold_d       = hold_q;
    cancel_d     = cancel_q;
    // First use after a bias write runs on user limits and consumes the flag.
    fresh_bias_d = (bias_active_q && fresh_bias_q) ? 1'b0 : fresh_bias_q;
    priority if (overload && burst_q != '0) begin
      cancel_d = 1'b1;
      burst_d  = burst_q - BURST_W'(1);
    end else if (burst_q == '0 && hold_q != '0 && hold_q <= HOLD_W'(HOLD_TICKS)) begin
      cancel_d = 1'b0;
      hold_d   = hold_q - HOLD_W'(1);
    end else if (hold_q == '0 || !overload) begin
      cancel_d = 1'b0;
      burst_d  = BURST_W'(CANCEL_BURST);
      hold_d   = HOLD_W'(HOLD_TICKS);
    end else begin
      cancel_d = cancel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q      <= BURST_W'(CANCEL_BURST);
      hold_q       <= HOLD_W'(HOLD_TICKS);
      cancel_q     <= 1'b0;
      fresh_bias_q <= 1'b0;
    end else begin
      if (advance) begin
        burst_q  <= burst_d;
        hold_q   <= hold_d;
        cancel_q <= cancel_d;
      end
      // Bias write re-arms the fresh flag; that it never coincides with a beat is up to the user, not enforced.
      if (cfg_we_i && cfg_idx_i == REG_BIAS_ACTIVE && cfg_data_i[0]) begin
        fresh_bias_q <= 1'b1;
      end else if (advance) begin
        fresh_bias_q <= fresh_bias_d;
      end
    end
  end

  // ---------------- result register ----------------
  logic force_over_q, torque_over_q, biased_q;
  mag_t fmag_q, tmag_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      force_over_q  <= f_over;
      torque_over_q <= t_over;
      fmag_q        <= fsum;
      tmag_q        <= tsum;
      biased_q      <= biased_sel;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign cancel_o              = cancel_q;
  assign force_over_o          = force_over_q;
  assign torque_over_o         = torque_over_q;
  assign force_mag_sq_o        = fmag_q;
  assign torque_mag_sq_o       = tmag_q;
  assign using_biased_limits_o = biased_q;

endmodule

/* src/wocm_sq3.sv */
// Squares the three signed components of one vector.
// Depends on wocm_pkg.
module wocm_sq3 (
  input  logic signed [wocm_pkg::COMP_W-1:0] a_i,
  input  logic signed [wocm_pkg::COMP_W-1:0] b_i,
  input  logic signed [wocm_pkg::COMP_W-1:0] c_i,
  output wocm_pkg::sq3_t                     sq_o
);
  import wocm_pkg::*;

  logic signed [MAG_W-1:0] pa, pb, pc;

  // Sign-extend to MAG_W first; most negative input squares to 2^38.
  assign pa = MAG_W'(a_i) * MAG_W'(a_i);
  assign pb = MAG_W'(b_i) * MAG_W'(b_i);
  assign pc = MAG_W'(c_i) * MAG_W'(c_i);

  assign sq_o.a = mag_t'(pa);
  assign sq_o.b = mag_t'(pb);
  assign sq_o.c = mag_t'(pc);

endmodule

/* dv/wrench_overload_cancel_monitor_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for wrench_overload_cancel_monitor_top: directed and random sample traffic,
// an in-order predictor of every result beat and a field-by-field checker.
// Depends on wocm_pkg and the block's sources.
module wrench_overload_cancel_monitor_top_tb;
  import wocm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX    = '1;
  localparam int unsigned COMP_MAX_MAG = 524288;
  localparam int unsigned COMP_MAX_POS = 524287;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = RANDOM_ITEMS / PHASES;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct {
    comp_t fx, fy, fz, tx, ty, tz;
  } sample_t;

  typedef struct {
    logic cancel;
    logic f_over;
    logic t_over;
    mag_t fsq;
    mag_t tsq;
    logic biased;
  } verdict_t;

  typedef enum int { SEQ_QUIET, SEQ_OVER, SEQ_EDGE, SEQ_NOISE } seq_kind_e;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [LIMIT_W-1:0]   cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  comp_t                force_x_i  = '0;
  comp_t                force_y_i  = '0;
  comp_t                force_z_i  = '0;
  comp_t                torque_x_i = '0;
  comp_t                torque_y_i = '0;
  comp_t                torque_z_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 cancel_o;
  logic                 force_over_o;
  logic                 torque_over_o;
  logic [MAG_W-1:0]     force_mag_sq_o;
  logic [MAG_W-1:0]     torque_mag_sq_o;
  logic                 using_biased_limits_o;

  wrench_overload_cancel_monitor_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .force_x_i             (force_x_i),
    .force_y_i             (force_y_i),
    .force_z_i             (force_z_i),
    .torque_x_i            (torque_x_i),
    .torque_y_i            (torque_y_i),
    .torque_z_i            (torque_z_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .cancel_o              (cancel_o),
    .force_over_o          (force_over_o),
    .torque_over_o         (torque_over_o),
    .force_mag_sq_o        (force_mag_sq_o),
    .torque_mag_sq_o       (torque_mag_sq_o),
    .using_biased_limits_o (using_biased_limits_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers and the cancel counters
  logic [LIMIT_W-1:0] lim_force_user, lim_torque_user, lim_force_biased, lim_torque_biased;
  logic               bias_on, bias_fresh, cancel_state;
  int                 burst_count, holdoff_count;

  verdict_t pending_verdicts[$];
  int       mismatches = 0;
  bit       steady     = 1'b0;

  function automatic mag_t sum_of_squares(comp_t a, comp_t b, comp_t c);
    longint sa, sb, sc;
    sa = a;
    sb = b;
    sc = c;
    return mag_t'(sa * sa + sb * sb + sc * sc);
  endfunction

  function automatic verdict_t predict_verdict(sample_t s);
    verdict_t v;
    longint   flim, tlim;
    logic     over;
    v.fsq    = sum_of_squares(s.fx, s.fy, s.fz);
    v.tsq    = sum_of_squares(s.tx, s.ty, s.tz);
    v.biased = bias_on && !bias_fresh;
    if (v.biased) begin
      flim = lim_force_biased;
      tlim = lim_torque_biased;
    end else begin
      if (bias_on) bias_fresh = 1'b0;
      flim = lim_force_user;
      tlim = lim_torque_user;
    end
    v.f_over = longint'(v.fsq) > flim * flim;
    v.t_over = longint'(v.tsq) > tlim * tlim;
    over = v.f_over || v.t_over;
    if (over && burst_count > 0) begin
      cancel_state = 1'b1;
      burst_count--;
    end else if (burst_count == 0 && holdoff_count > 0 && holdoff_count <= HOLD_TICKS) begin
      cancel_state = 1'b0;
      holdoff_count--;
    end else if (holdoff_count == 0 || !over) begin
      cancel_state  = 1'b0;
      burst_count   = CANCEL_BURST;
      holdoff_count = HOLD_TICKS;
    end
    v.cancel = cancel_state;
    return v;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic comp_t rand_comp(int unsigned lo, int unsigned hi);
    int m;
    m = $urandom_range(hi, lo);
    if ($urandom_range(1)) return comp_t'(-m);
    return (m > COMP_MAX_POS) ? comp_t'(COMP_MAX_POS) : comp_t'(m);
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit(int phase);
    case (phase)
      1: return LIMIT_MAX;
      2: return LIMIT_W'(1);
      default: begin
        if ($urandom_range(3) == 0) return LIMIT_W'($urandom_range(COMP_MAX_POS, 1));
        return LIMIT_W'($urandom_range(60000, 1));
      end
    endcase
  endfunction

  function automatic sample_t make_sample(seq_kind_e kind);
    comp_t       c[6];
    int unsigned fmax, fmin, tmax, tmin, l, mag;
    int          pick, axis;
    fmax = (lim_force_user > lim_force_biased) ? lim_force_user : lim_force_biased;
    fmin = (lim_force_user > lim_force_biased) ? lim_force_biased : lim_force_user;
    tmax = (lim_torque_user > lim_torque_biased) ? lim_torque_user : lim_torque_biased;
    tmin = (lim_torque_user > lim_torque_biased) ? lim_torque_biased : lim_torque_user;
    // Half the smaller limit per axis stays under either limit set
    for (int k = 0; k < 3; k++) begin
      c[k]     = rand_comp(0, fmin / 2);
      c[k + 3] = rand_comp(0, tmin / 2);
    end
    case (kind)
      SEQ_OVER: begin
        // 3 * (0.6 L)^2 exceeds L^2, so the vector is over either limit set
        pick = $urandom_range(2);
        for (int k = 0; k < 3; k++) begin
          if (pick != 1) c[k] = rand_comp(fmax * 3 / 5 + 1, COMP_MAX_MAG);
          if (pick != 0) c[k + 3] = rand_comp(tmax * 3 / 5 + 1, COMP_MAX_MAG);
        end
      end
      SEQ_EDGE: begin
        pick = $urandom_range(3);
        if (pick < 2) l = pick[0] ? lim_force_biased : lim_force_user;
        else l = pick[0] ? lim_torque_biased : lim_torque_user;
        mag = l + $urandom_range(4);
        mag = (mag < 2) ? 0 : mag - 2;
        if (mag > COMP_MAX_MAG) mag = COMP_MAX_MAG;
        axis = (pick < 2) ? 0 : 3;
        for (int k = 0; k < 3; k++) c[axis + k] = '0;
        c[axis + $urandom_range(2)] = rand_comp(mag, mag);
      end
      SEQ_NOISE: begin
        for (int k = 0; k < 6; k++) c[k] = comp_t'($urandom);
      end
      default: ;
    endcase
    return '{c[0], c[1], c[2], c[3], c[4], c[5]};
  endfunction

  task automatic send_sample(sample_t s);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    force_x_i  <= s.fx;
    force_y_i  <= s.fy;
    force_z_i  <= s.fz;
    torque_x_i <= s.tx;
    torque_y_i <= s.ty;
    torque_z_i <= s.tz;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(predict_verdict(s));
  endtask

  // Drop valid, let every expected beat arrive, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_FORCE_USER:    lim_force_user    = data;
      REG_TORQUE_USER:   lim_torque_user   = data;
      REG_FORCE_BIASED:  lim_force_biased  = data;
      REG_TORQUE_BIASED: lim_torque_biased = data;
      REG_BIAS_ACTIVE: begin
        bias_on = data[0];
        if (data[0]) bias_fresh = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, mag_t expv, mag_t actv);
    if (expv !== actv) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, expv, actv);
    end
  endfunction

  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none actual fsq %0h tsq %0h",
                 $time, force_mag_sq_o, torque_mag_sq_o);
      end else begin
        v = pending_verdicts.pop_front();
        check_field("cancel", mag_t'(v.cancel), mag_t'(cancel_o));
        check_field("force_over", mag_t'(v.f_over), mag_t'(force_over_o));
        check_field("torque_over", mag_t'(v.t_over), mag_t'(torque_over_o));
        check_field("force_mag_sq", v.fsq, force_mag_sq_o);
        check_field("torque_mag_sq", v.tsq, torque_mag_sq_o);
        check_field("using_biased_limits", mag_t'(v.biased), mag_t'(using_biased_limits_o));
      end
    end
  end

  // Receiver stalls
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (steady) begin
        out_ready_i <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end else begin
        out_ready_i <= !out_ready_i;
        hold_cycles = pick_gap();
      end
    end
  end

  task automatic test_default_limits();
    // exactly at a limit is not over, one past it is
    send_sample('{50000, 0, 0, 0, 0, 0});
    send_sample('{0, 50001, 0, 0, 0, 0});
    send_sample('{0, 0, 0, 0, -5000, 0});
    send_sample('{0, 0, 0, 0, 0, -5001});
  endtask

  task automatic test_extremes();
    send_sample('{-524288, -524288, -524288, -524288, -524288, -524288});
    send_sample('{524287, 524287, 524287, 524287, 524287, 524287});
    send_sample('{0, 0, 0, 0, 0, 0});
    send_sample('{-524288, 524287, -1, 1, -524288, 524287});
  endtask

  task automatic test_burst_reload();
    steady = 1'b1;
    repeat (CANCEL_BURST + 2) send_sample('{524287, 0, 0, 0, 0, 0});
    repeat (2) send_sample('{0, 0, 0, 0, 0, 0});
    steady = 1'b0;
  endtask

  task automatic test_bias_selection();
    // first tick after the bias write still uses the user limits
    write_reg(REG_BIAS_ACTIVE, LIMIT_W'(1));
    send_sample('{20000, 0, 0, 0, 0, 0});
    send_sample('{20000, 0, 0, 0, 0, 0});
    write_reg(REG_BIAS_ACTIVE, LIMIT_W'(1));
    send_sample('{0, 0, 0, 0, 900, 0});
    write_reg(REG_BIAS_ACTIVE, LIMIT_W'(0));
    send_sample('{20000, 0, 0, 0, 900, 0});
  endtask

  task automatic test_limit_extremes();
    write_reg(REG_FORCE_USER, '0);
    write_reg(REG_TORQUE_USER, '0);
    send_sample('{0, 0, 0, 0, 0, 0});
    send_sample('{0, 0, 1, 0, 0, 0});
    send_sample('{0, 0, 0, 0, -1, 0});
    write_reg(REG_FORCE_USER, LIMIT_MAX);
    write_reg(REG_TORQUE_USER, LIMIT_MAX);
    send_sample('{524287, 0, 0, -524288, 0, 0});
    send_sample('{524287, 524287, 0, 0, 0, 0});
    // writes to unused indexes leave every register alone
    write_reg(REG_SPARE_LO, '0);
    write_reg(REG_SPARE_HI, '1);
    send_sample('{524287, 0, 0, 0, 524287, 0});
    write_reg(REG_FORCE_USER, FORCE_USER_RST);
    write_reg(REG_TORQUE_USER, TORQUE_USER_RST);
    write_reg(REG_FORCE_BIASED, FORCE_BIASED_RST);
    write_reg(REG_TORQUE_BIASED, TORQUE_BIASED_RST);
  endtask

  task automatic test_random_traffic();
    int          sent, phase, run, r;
    seq_kind_e   kind;
    logic [LIMIT_W-1:0] bias_word;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < PHASES && sent >= phase * PHASE_ITEMS) begin
        steady = (phase % 3 == 2);
        write_reg(REG_FORCE_USER, rand_limit(phase));
        write_reg(REG_TORQUE_USER, rand_limit(phase));
        write_reg(REG_FORCE_BIASED, rand_limit(phase));
        write_reg(REG_TORQUE_BIASED, rand_limit(phase));
        bias_word = LIMIT_W'($urandom);
        write_reg(REG_BIAS_ACTIVE, bias_word);
        phase++;
      end else if ($urandom_range(39) == 0) begin
        bias_word = LIMIT_W'($urandom);
        write_reg(REG_BIAS_ACTIVE, bias_word);
      end
      r = $urandom_range(99);
      if (r < 45) kind = SEQ_OVER;
      else if (r < 75) kind = SEQ_QUIET;
      else if (r < 90) kind = SEQ_EDGE;
      else kind = SEQ_NOISE;
      // long overload runs reach the end of the hold-off
      if (kind == SEQ_OVER && $urandom_range(6) == 0) run = $urandom_range(130, 100);
      else run = $urandom_range(12, 1);
      repeat (run) begin
        send_sample(make_sample(kind));
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    lim_force_user    = FORCE_USER_RST;
    lim_torque_user   = TORQUE_USER_RST;
    lim_force_biased  = FORCE_BIASED_RST;
    lim_torque_biased = TORQUE_BIASED_RST;
    bias_on           = 1'b0;
    bias_fresh        = 1'b0;
    cancel_state      = 1'b0;
    burst_count       = CANCEL_BURST;
    holdoff_count     = HOLD_TICKS;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_limits();
    test_extremes();
    test_burst_reload();
    test_bias_selection();
    test_limit_extremes();
    test_random_traffic();
    wait_idle();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
src/wocm_pkg.sv
src/wocm_sq3.sv
src/wrench_overload_cancel_monitor_top.sv
dv/wrench_overload_cancel_monitor_top_tb.sv
